// ===== hdl/fpp_pkg.sv =====
`default_nettype none
package fpp_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int BYTE_W     = 8;
  localparam int FILL_W     = 4;
  localparam int PAIR_W     = 2 * BYTE_W;

  // Depth of the result queue in front of the output port.
  localparam int QDEPTH     = 3;
  localparam int QIDX_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_BYTE = 8'h55;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_X,
    PH_DIST,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    logic              frame_done;
    logic              pop_valid;
    logic [BYTE_W-1:0] pop_x;
    logic [BYTE_W-1:0] pop_dist;
    logic [FILL_W-1:0] fill_count;
  } res_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fpp_if.sv =====
`default_nettype none
interface fpp_in_if
  import fpp_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface fpp_out_if
  import fpp_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              frame_done;
  logic              pop_valid;
  logic [BYTE_W-1:0] pop_x;
  logic [BYTE_W-1:0] pop_dist;
  logic [FILL_W-1:0] fill_count;

  modport source (output valid, frame_done, pop_valid, pop_x, pop_dist, fill_count,
                  input ready);
  modport sink   (input valid, frame_done, pop_valid, pop_x, pop_dist, fill_count,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/fpp_pair_ram.sv =====
`default_nettype none
module fpp_pair_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fpp_out_queue.sv =====
`default_nettype none
module fpp_out_queue
  import fpp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire res_t              push_data,
  output logic      [QCNT_W-1:0] level,
  fpp_out_if.source              rsp
);

  res_t              entries [QDEPTH];
  logic [QIDX_W-1:0] head;
  logic [QIDX_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  logic              pop;
  res_t              front;

  function automatic logic [QIDX_W-1:0] idx_inc(input logic [QIDX_W-1:0] i);
    logic [QIDX_W-1:0] r;
    if (i == QIDX_W'(QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  assign pop   = rsp.valid && rsp.ready;
  assign level = count;
  assign front = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= idx_inc(tail);
      end
      if (pop) begin
        head <= idx_inc(head);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rsp.valid      = (count != '0);
  assign rsp.frame_done = front.frame_done;
  assign rsp.pop_valid  = front.pop_valid;
  assign rsp.pop_x      = front.pop_x;
  assign rsp.pop_dist   = front.pop_dist;
  assign rsp.fill_count = front.fill_count;

endmodule
`default_nettype wire

// ===== hdl/framed_pair_parser_with_overwrite_fifo.sv =====
// A beat's result is held in stage one while the pair memory read completes, then enters
// the output queue, from which rsp presents it.
// Throughput: one beat per cycle, bytes and pops mixed freely; the block keeps accepting
// while stage one and its three-entry output queue together hold at most two results.
// Reset (synchronous, active high) clears the deframer, pointers, count and output queue.
// The pair memory is not cleared: only entries that were written can ever be popped.
`default_nettype none
module framed_pair_parser_with_overwrite_fifo
  import fpp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  fpp_in_if.sink    req,
  fpp_out_if.source rsp
);

  // All bookkeeping for a beat happens in the cycle it is accepted: the deframer step,
  // the pointer and count update, and the memory access. A push writes the memory at the
  // accept edge and a pop issues its read there, so a pop that follows a push to the same
  // entry already sees the new pair. No forwarding path is needed because a single beat
  // never both writes and reads the memory.

  logic              accept;
  phase_t            phase;
  phase_t            phase_next;
  logic [BYTE_W-1:0] held_x;
  logic [BYTE_W-1:0] held_x_next;
  logic [BYTE_W-1:0] held_dist;
  logic [BYTE_W-1:0] held_dist_next;
  ptr_t              write_ptr;
  ptr_t              write_ptr_next;
  ptr_t              read_ptr;
  ptr_t              read_ptr_next;
  ptr_t              entry_count;
  ptr_t              entry_count_next;
  logic              do_push;
  logic              do_pop;

  // Stage one holds the control part of a result while the memory read completes.
  logic              s1_valid;
  logic              s1_packet;
  logic              s1_pop;
  logic [FILL_W-1:0] s1_fill;

  logic [PAIR_W-1:0] rd_pair;
  res_t              s1_res;
  logic [QCNT_W-1:0] q_level;

  assign accept = req.valid && req.ready;

  // Ready is decided from registered state only: accept while the results in flight
  // (stage one plus the queue) leave one queue slot free for this beat.
  assign req.ready = ((QCNT_W + 1)'(q_level) + (QCNT_W + 1)'(s1_valid))
                     < (QCNT_W + 1)'(QDEPTH);

  always_comb begin
    phase_next       = phase;
    held_x_next      = held_x;
    held_dist_next   = held_dist;
    write_ptr_next   = write_ptr;
    read_ptr_next    = read_ptr;
    entry_count_next = entry_count;
    do_push          = 1'b0;
    do_pop           = 1'b0;

    if (accept) begin
      if (req.action == ACT_BYTE) begin
        unique case (phase)
          PH_HEADER: begin
            if (req.rx_byte == HDR_BYTE) begin
              phase_next = PH_X;
            end
          end
          PH_X: begin
            held_x_next = req.rx_byte;
            phase_next  = PH_DIST;
          end
          PH_DIST: begin
            held_dist_next = req.rx_byte;
            phase_next     = PH_TAIL;
          end
          PH_TAIL: begin
            // A wrong tail byte simply drops the packet; it is not retried as a header.
            do_push    = (req.rx_byte == TAIL_BYTE);
            phase_next = PH_HEADER;
          end
          default: begin
            phase_next = PH_HEADER;
          end
        endcase
      end else if (write_ptr != read_ptr) begin
        do_pop        = 1'b1;
        read_ptr_next = ptr_inc(read_ptr);
        if (entry_count != '0) begin
          entry_count_next = entry_count - 1'b1;
        end
      end
    end

    // When the ring is full, a push overwrites the oldest pair: the read pointer steps
    // past it and the count stays where it is.
    if (do_push) begin
      write_ptr_next = ptr_inc(write_ptr);
      if (ptr_inc(write_ptr) == read_ptr) begin
        read_ptr_next = ptr_inc(read_ptr);
      end else begin
        entry_count_next = entry_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      held_x      <= '0;
      held_dist   <= '0;
      write_ptr   <= '0;
      read_ptr    <= '0;
      entry_count <= '0;
      s1_valid    <= 1'b0;
    end else begin
      phase       <= phase_next;
      held_x      <= held_x_next;
      held_dist   <= held_dist_next;
      write_ptr   <= write_ptr_next;
      read_ptr    <= read_ptr_next;
      entry_count <= entry_count_next;
      s1_valid    <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_packet <= do_push;
      s1_pop    <= do_pop;
      s1_fill   <= FILL_W'(entry_count_next);
    end
  end

  // The pair memory keeps x in the high byte and the distance in the low byte.
  fpp_pair_ram #(
    .DEPTH (FIFO_DEPTH),
    .WIDTH (PAIR_W)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (write_ptr),
    .wdata ({held_x, held_dist}),
    .re    (do_pop),
    .raddr (read_ptr),
    .rdata (rd_pair)
  );

  // A pop that found the ring empty, and every byte beat, report zero pair fields.
  always_comb begin
    s1_res.frame_done = s1_packet;
    s1_res.pop_valid  = s1_pop;
    s1_res.pop_x      = s1_pop ? rd_pair[PAIR_W-1:BYTE_W] : '0;
    s1_res.pop_dist   = s1_pop ? rd_pair[BYTE_W-1:0] : '0;
    s1_res.fill_count = s1_fill;
  end

  fpp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (s1_res),
    .level     (q_level),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

// ===== hdl/fpp_checker.sv =====
`default_nettype none
module fpp_port_checks
  import fpp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              rsp_valid,
  input wire logic              rsp_ready,
  input wire logic              frame_done,
  input wire logic              pop_valid,
  input wire logic [BYTE_W-1:0] pop_x,
  input wire logic [BYTE_W-1:0] pop_dist,
  input wire logic [FILL_W-1:0] fill_count
);

  // A waiting result keeps its contents until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_done) && $stable(pop_valid)
      && $stable(pop_x) && $stable(pop_dist) && $stable(fill_count))
    else $error("result changed while stalled");

  // A beat is either a byte or a pop, never both.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(frame_done && pop_valid))
    else $error("result claims both a packet and a pop");

  // Pair fields are zero unless a pair was actually popped.
  a_zero_pair: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !pop_valid |-> pop_x == '0 && pop_dist == '0)
    else $error("pair fields set without a pop");

  // Nothing is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result shown right after reset");

endmodule

bind framed_pair_parser_with_overwrite_fifo fpp_port_checks u_fpp_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .frame_done (rsp.frame_done),
  .pop_valid  (rsp.pop_valid),
  .pop_x      (rsp.pop_x),
  .pop_dist   (rsp.pop_dist),
  .fill_count (rsp.fill_count)
);
`default_nettype wire

// ===== tb/fpp_checker.sv =====
`timescale 1ns / 1ps
module fpp_checker
  import fpp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  fpp_in_if    req,
  fpp_out_if   rsp,
  output int   errors,
  output int   pending,
  output int   n_packets,
  output int   n_overwrites,
  output int   n_data_pops,
  output int   n_empty_pops
);

  // Shadow copy of the deframer and the ring buffer.
  phase_t            frame_phase;
  logic [BYTE_W-1:0] held_x;
  logic [BYTE_W-1:0] held_dist;
  logic [PAIR_W-1:0] pairs [FIFO_DEPTH];
  ptr_t              wr_ptr;
  ptr_t              rd_ptr;
  int                held_count;

  res_t owed_replies [$];

  function automatic ptr_t wrap_inc(input ptr_t p);
    return ptr_t'((int'(p) + 1) % FIFO_DEPTH);
  endfunction

  // One accepted beat: update the shadow state and return the reply it owes.
  function automatic res_t deframe_step(input logic act, input logic [BYTE_W-1:0] b);
    res_t r;
    ptr_t nxt;
    r = '0;
    if (act == ACT_BYTE) begin
      case (frame_phase)
        PH_HEADER: begin
          if (b == HDR_BYTE) frame_phase = PH_X;
        end
        PH_X: begin
          held_x      = b;
          frame_phase = PH_DIST;
        end
        PH_DIST: begin
          held_dist   = b;
          frame_phase = PH_TAIL;
        end
        default: begin
          if (b == TAIL_BYTE) begin
            pairs[wr_ptr] = {held_x, held_dist};
            nxt = wrap_inc(wr_ptr);
            if (nxt == rd_ptr) begin
              // Buffer full: the oldest pair is lost and the count holds.
              rd_ptr = wrap_inc(rd_ptr);
              n_overwrites++;
            end else begin
              held_count++;
            end
            wr_ptr       = nxt;
            r.frame_done = 1'b1;
            n_packets++;
          end
          frame_phase = PH_HEADER;
        end
      endcase
    end else if (wr_ptr != rd_ptr) begin
      {r.pop_x, r.pop_dist} = pairs[rd_ptr];
      r.pop_valid = 1'b1;
      rd_ptr      = wrap_inc(rd_ptr);
      if (held_count > 0) held_count--;
      n_data_pops++;
    end else begin
      n_empty_pops++;
    end
    r.fill_count = FILL_W'(held_count);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    errors       = 0;
    pending      = 0;
    n_packets    = 0;
    n_overwrites = 0;
    n_data_pops  = 0;
    n_empty_pops = 0;
  end

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      frame_phase = PH_HEADER;
      held_x      = '0;
      held_dist   = '0;
      wr_ptr      = '0;
      rd_ptr      = '0;
      held_count  = 0;
      owed_replies.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got = '{rsp.frame_done, rsp.pop_valid, rsp.pop_x, rsp.pop_dist, rsp.fill_count};
        if (owed_replies.size() == 0) begin
          errors++;
          $display("%0t: unexpected reply, expected none, actual %p", $time, got);
        end else begin
          want = owed_replies.pop_front();
          check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
          check_field("pop_valid", 8'(want.pop_valid), 8'(got.pop_valid));
          check_field("pop_x", want.pop_x, got.pop_x);
          check_field("pop_dist", want.pop_dist, got.pop_dist);
          check_field("fill_count", 8'(want.fill_count), 8'(got.fill_count));
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        owed_replies.push_back(deframe_step(req.action, req.rx_byte));
      end
    end
    pending = owed_replies.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import fpp_pkg::*;

  // Worst case is roughly a thousand beats, each with a long sender gap and a
  // long receiver stall, plus one long hold-off; this limit leaves ample room.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BEATS = 900;
  localparam int SEG_LEN      = 100;

  logic clk;
  logic rst;

  // When calm is set, neither side inserts random idle cycles; a requested hold-off still happens.
  bit   calm         = 1'b0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit   hold_request = 1'b0;
  int   beats_sent   = 0;
  int   long_holds   = 0;
  int   cycle_cnt    = 0;

  int errors;
  int pending;
  int n_packets;
  int n_overwrites;
  int n_data_pops;
  int n_empty_pops;

  fpp_in_if  req_if ();
  fpp_out_if rsp_if ();

  framed_pair_parser_with_overwrite_fifo u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // The checker sees both channels, predicts every reply and counts mismatches.
  fpp_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_if),
    .rsp          (rsp_if),
    .errors       (errors),
    .pending      (pending),
    .n_packets    (n_packets),
    .n_overwrites (n_overwrites),
    .n_data_pops  (n_data_pops),
    .n_empty_pops (n_empty_pops)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offer one beat and hold it until the block takes it. Valid stays high
  // into the next beat when there is no gap, so it is never dropped and
  // raised within one time step.
  task automatic send_beat(input logic act, input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.rx_byte <= b;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    beats_sent++;
  endtask

  // A pop carries a random byte, which the block must ignore.
  task automatic send_pop();
    send_beat(ACT_POP, 8'($urandom));
  endtask

  // A full frame; now and then a pop is slipped in between its bytes, which
  // must leave the deframer where it was.
  task automatic send_frame(input logic [BYTE_W-1:0] x, input logic [BYTE_W-1:0] d,
                            input logic [BYTE_W-1:0] tail);
    logic [BYTE_W-1:0] frame [4];
    frame = '{HDR_BYTE, x, d, tail};
    foreach (frame[i]) begin
      if ($urandom_range(0, 9) == 0) send_pop();
      send_beat(ACT_BYTE, frame[i]);
    end
  endtask

  // Receiver: random stalls, stretches of steady acceptance, and one long
  // hold-off on request so that the output queue fills and input backs up.
  initial begin
    int n;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_if.ready <= 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        long_holds++;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      rsp_if.ready <= 1'b1;
      repeat (calm ? 8 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: if the run has not ended by the limit, it is a failure.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int seg;
    int pop_pct;
    int r;
    int start;
    int seg_end;
    logic [BYTE_W-1:0] tail;

    rst            <= 1'b1;
    req_if.valid   <= 1'b0;
    req_if.action  <= ACT_BYTE;
    req_if.rx_byte <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A pop on the empty buffer comes first.
    send_beat(ACT_POP, 8'hFF);
    // Good frames with extreme payloads, including payload bytes equal to
    // the header and tail markers.
    send_beat(ACT_BYTE, HDR_BYTE);
    send_beat(ACT_BYTE, 8'h00);
    send_beat(ACT_BYTE, 8'hFF);
    send_beat(ACT_BYTE, TAIL_BYTE);
    send_beat(ACT_BYTE, HDR_BYTE);
    send_beat(ACT_BYTE, 8'hFF);
    send_beat(ACT_BYTE, 8'h00);
    send_beat(ACT_BYTE, TAIL_BYTE);
    send_beat(ACT_BYTE, HDR_BYTE);
    send_beat(ACT_BYTE, HDR_BYTE);
    send_beat(ACT_BYTE, TAIL_BYTE);
    send_beat(ACT_BYTE, TAIL_BYTE);
    // A bad tail that happens to be the header byte must not start a frame,
    // so the byte after it is treated as noise rather than as an x byte.
    send_beat(ACT_BYTE, HDR_BYTE);
    send_beat(ACT_BYTE, 8'h12);
    send_beat(ACT_BYTE, 8'h34);
    send_beat(ACT_BYTE, HDR_BYTE);
    send_beat(ACT_BYTE, 8'h12);
    // A lone tail byte while searching for a header is ignored.
    send_beat(ACT_BYTE, TAIL_BYTE);
    // Drain the three stored pairs, then pop once more on empty.
    repeat (4) send_pop();
    // A pop in the middle of a frame; the frame carries on in the random part.
    send_beat(ACT_BYTE, HDR_BYTE);
    send_pop();

    // Random part, in segments. The pop share changes per segment so the
    // buffer swings between full (with overwrites) and empty. One segment
    // runs with the receiver held off for a long stretch while the sender
    // keeps offering beats back to back.
    start = beats_sent;
    seg   = 0;
    while (beats_sent - start < RANDOM_BEATS) begin
      case (seg % 4)
        0:       pop_pct = 10;
        1:       pop_pct = 60;
        2:       pop_pct = 30;
        default: pop_pct = 80;
      endcase
      calm = (seg == 2) || (seg % 5 == 3);
      if (seg == 2) hold_request = 1'b1;
      seg_end = beats_sent + SEG_LEN;
      while (beats_sent < seg_end) begin
        r = $urandom_range(0, 99);
        if (r < pop_pct) begin
          send_pop();
        end else begin
          r = $urandom_range(0, 99);
          if (r < 80) begin
            send_frame(8'($urandom), 8'($urandom), TAIL_BYTE);
          end else if (r < 92) begin
            // Broken frame: any tail but the right one, often the header byte.
            tail = ($urandom_range(0, 2) == 0) ? HDR_BYTE : 8'($urandom);
            if (tail == TAIL_BYTE) tail = ~tail;
            send_frame(8'($urandom), 8'($urandom), tail);
          end else begin
            // Stray byte, sometimes a header that leaves a frame half open.
            send_beat(ACT_BYTE, ($urandom_range(0, 3) == 0) ? HDR_BYTE : 8'($urandom));
          end
        end
      end
      seg++;
    end
    calm = 1'b0;
    req_if.valid <= 1'b0;

    // Wait for every owed reply, then keep watching for anything stray before the summary.
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("Run covered %0d beats: %0d frames stored, %0d of them into a full buffer.",
             beats_sent, n_packets, n_overwrites);
    $display("Pops returned %0d pairs and found the buffer empty %0d times; %0d long hold-off.",
             n_data_pops, n_empty_pops, long_holds);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
